// ===== src/assert_macros.svh =====
// assertion macros shared by the sorted list design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clock edge outside reset
`define SLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication on every rising clock edge outside reset
`define SLI_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== src/sli_pkg.sv =====
// shared types and constants of the sorted list insert/delete block
package sli_pkg;

  localparam int VAL_W     = 32;
  localparam int DEPTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_DELETE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  value;
  } cell_cmd_t;

endpackage

// ===== src/sorted_list_insert_delete_top.sv =====
// top level of the sorted list insert/delete block: cell chain and sequencer
// an item is taken in S_IDLE, the chain updated in S_UPDATE, then one result per cycle
// while out_tready allows; listing n stored values gives n results (one when empty)
// the listing rotates the cell chain by one place per transfer, restoring the order at the end
// synchronous active-low reset empties the list and clears the output valid flag
module sorted_list_insert_delete_top #(
  parameter int DEPTH = sli_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [sli_pkg::VAL_W-1:0] in_tdata,   // value
  input  logic                     in_tuser,   // mode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [sli_pkg::VAL_W-1:0] out_tdata,  // element
  output logic                     out_tlast,
  output logic [2:0]               out_tuser   // status[1:0], list_empty
);
  import sli_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_UPDATE, S_STREAM} state_t;

  state_t                  state_r;
  mode_t                   mode_r;
  logic signed [VAL_W-1:0] value_r;
  status_t                 status_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           remain_r;
  logic                    out_tvalid_r;
  logic [VAL_W-1:0]        out_tdata_r;
  logic                    out_tlast_r;
  logic [2:0]              out_tuser_r;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0]        vld;
  logic [DEPTH-1:0]        abv;
  logic [DEPTH-1:0]        mat;
  logic                    found, full, empty, load, last_item;

  assign found     = |mat;
  assign full      = count_r == CW'(DEPTH);
  assign empty     = count_r == '0;
  assign load      = (state_r == S_STREAM) && (!out_tvalid_r || out_tready);
  assign last_item = empty || (remain_r == CW'(1));

  always_comb begin
    cmd.value = value_r;
    cmd.op    = CELL_HOLD;
    priority if (state_r == S_UPDATE) begin
      if (mode_r == MODE_INSERT && !full) begin
        cmd.op = CELL_INSERT;
      end else if (mode_r == MODE_DELETE && found) begin
        cmd.op = CELL_DELETE;
      end
    end else if (load && !empty) begin
      cmd.op = CELL_ROTATE;
    end else begin
      cmd.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sli_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_above ((i == 0) ? 1'b0 : abv[(i == 0) ? 0 : i - 1]),
      .prev_entry ((i == 0) ? '0 : ent[(i == 0) ? 0 : i - 1]),
      .prev_valid ((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i - 1]),
      .next_entry ((i == DEPTH - 1) ? '0 : ent[(i == DEPTH - 1) ? i : i + 1]),
      .next_valid ((i == DEPTH - 1) ? 1'b0 : vld[(i == DEPTH - 1) ? i : i + 1]),
      .head_entry (ent[0]),
      .entry      (ent[i]),
      .valid      (vld[i]),
      .above      (abv[i]),
      .match      (mat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && !load) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            mode_r  <= mode_t'(in_tuser);
            value_r <= in_tdata;
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (mode_r == MODE_INSERT) begin
            status_r <= full ? ST_FULL : ST_OK;
            count_r  <= full ? count_r : CW'(count_r + 1'b1);
            remain_r <= full ? count_r : CW'(count_r + 1'b1);
          end else begin
            status_r <= found ? ST_OK : ST_NOT_FOUND;
            count_r  <= found ? CW'(count_r - 1'b1) : count_r;
            remain_r <= found ? CW'(count_r - 1'b1) : count_r;
          end
          state_r <= S_STREAM;
        end
        S_STREAM: begin
          if (load) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= empty ? '0 : ent[0];
            out_tlast_r  <= last_item;
            out_tuser_r  <= {status_r, empty};
            remain_r     <= CW'(remain_r - 1'b1);
            if (last_item) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  `SLI_ASSERT(a_count_range, count_r <= CW'(DEPTH), "entry count above depth")
  `SLI_ASSERT(a_valid_count, $countones(vld) == int'(count_r), "valid cells differ from count")
  `SLI_ASSERT(a_valid_packed, $onehot({1'b0, vld} + {{DEPTH{1'b0}}, 1'b1}), "valid cells not packed from head")
  `SLI_ASSERT_IMP(a_update_once, state_r == S_UPDATE, state_r != $past(state_r), "update held for more than one cycle")

endmodule

// ===== src/sli_cell.sv =====
// one storage cell of the sorted list chain
module sli_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sli_pkg::cell_cmd_t               cmd,
  input  logic                             prev_above,
  input  logic signed [sli_pkg::VAL_W-1:0] prev_entry,
  input  logic                             prev_valid,
  input  logic signed [sli_pkg::VAL_W-1:0] next_entry,
  input  logic                             next_valid,
  input  logic signed [sli_pkg::VAL_W-1:0] head_entry,
  output logic signed [sli_pkg::VAL_W-1:0] entry,
  output logic                             valid,
  output logic                             above,
  output logic                             match
);
  import sli_pkg::*;

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    valid_r, valid_nxt;
  logic                    ge;

  assign ge    = entry_r >= cmd.value;
  assign above = !valid_r || ge;
  assign match = valid_r && (entry_r == cmd.value);
  assign entry = entry_r;
  assign valid = valid_r;

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    unique case (cmd.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (prev_above) begin
          entry_nxt = prev_entry;
          valid_nxt = prev_valid;
        end else if (above) begin
          entry_nxt = cmd.value;
          valid_nxt = 1'b1;
        end
      end
      CELL_DELETE: begin
        if (valid_r && ge) begin
          entry_nxt = next_entry;
          valid_nxt = next_valid;
        end
      end
      CELL_ROTATE: begin
        if (valid_r) begin
          entry_nxt = next_valid ? next_entry : head_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule
